### rtl/core/tnf_pkg.sv
// Package for the telnet receive negotiation filter.
// Holds the protocol byte codes, option codes and the parser phase type.
// No dependencies.
package tnf_pkg;

  localparam logic [7:0] CMD_IAC  = 8'd255;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_SE   = 8'd240;

  localparam logic [7:0] OPT_BIN   = 8'd0;
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_NAWS  = 8'd31;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_IAC    = 3'd1,
    PH_WILL   = 3'd2,
    PH_WONT   = 3'd3,
    PH_DO     = 3'd4,
    PH_DONT   = 3'd5,
    PH_SUB    = 3'd6,
    PH_SUBIAC = 3'd7
  } phase_t;

endpackage

### rtl/core/tnf_rx_if.sv
// Channel carrying received telnet bytes into the filter.
// Valid/ready handshake; no package dependency.
interface tnf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

### rtl/core/tnf_res_if.sv
// Channel carrying filter results: payload bytes and negotiation replies.
// Valid/ready handshake; no package dependency.
interface tnf_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] reply_command;
  logic [7:0] reply_option;
  logic       echo_on;
  logic       sga_on;
  logic       binary_on;
  logic       chunk_last;

  modport source (
    output valid, output kind, output payload_byte, output reply_command,
    output reply_option, output echo_on, output sga_on, output binary_on,
    output chunk_last, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input reply_command,
    input reply_option, input echo_on, input sga_on, input binary_on,
    input chunk_last, output ready
  );
endinterface

### rtl/core/telnet_receive_negotiation_filter.sv
// Telnet receive negotiation filter: splits a received byte stream into host
// payload and negotiation replies. Takes one byte per clock while not stalled.
// A byte is held in an input register, decoded against the parser phase and the
// option flags, and its result (if any) is registered in an output register.
// Input stalls only when the output register is full, its result is not taken,
// and the held byte produces a result. Uses tnf_pkg, tnf_rx_if and tnf_res_if.
module telnet_receive_negotiation_filter (
  input  logic          clk,
  input  logic          rst,
  tnf_rx_if.sink        rx,
  tnf_res_if.source     result
);
  import tnf_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // parser state
  phase_t phase, phase_next;
  logic   echo_flag, echo_flag_next;
  logic   sga_flag, sga_flag_next;
  logic   binary_flag, binary_flag_next;

  // output register
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_data;
  logic [7:0] out_cmd;
  logic [7:0] out_opt;
  logic       out_echo;
  logic       out_sga;
  logic       out_bin;
  logic       out_last;

  logic       emit;
  logic       emit_kind;
  logic [7:0] emit_data;
  logic [7:0] emit_cmd;
  logic       out_free;
  logic       step;

  assign out_free = !out_valid || result.ready;
  assign step     = in_valid && (!emit || out_free);
  assign rx.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
      in_last <= rx.chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DATA;
      echo_flag   <= 1'b0;
      sga_flag    <= 1'b0;
      binary_flag <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      echo_flag   <= echo_flag_next;
      sga_flag    <= sga_flag_next;
      binary_flag <= binary_flag_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    echo_flag_next   = echo_flag;
    sga_flag_next    = sga_flag;
    binary_flag_next = binary_flag;
    emit             = 1'b0;
    emit_kind        = KIND_DATA;
    emit_data        = 8'd0;
    emit_cmd         = 8'd0;
    case (phase)
      PH_DATA: begin
        if (in_byte == CMD_IAC) begin
          phase_next = PH_IAC;
        end else begin
          emit      = 1'b1;
          emit_data = in_byte;
        end
      end
      PH_IAC: begin
        case (in_byte)
          CMD_IAC: begin
            emit       = 1'b1;
            emit_data  = CMD_IAC;
            phase_next = PH_DATA;
          end
          CMD_WILL: phase_next = PH_WILL;
          CMD_WONT: phase_next = PH_WONT;
          CMD_DO:   phase_next = PH_DO;
          CMD_DONT: phase_next = PH_DONT;
          CMD_SB:   phase_next = PH_SUB;
          default:  phase_next = PH_DATA;
        endcase
      end
      PH_WILL: begin
        emit       = 1'b1;
        emit_kind  = KIND_REPLY;
        phase_next = PH_DATA;
        case (in_byte)
          OPT_SGA: begin
            sga_flag_next = 1'b1;
            emit_cmd      = CMD_DO;
          end
          OPT_BIN: begin
            binary_flag_next = 1'b1;
            emit_cmd         = CMD_DO;
          end
          OPT_TTYPE, OPT_NAWS: emit_cmd = CMD_DO;
          default:             emit_cmd = CMD_DONT; // echo from client refused too
        endcase
      end
      PH_DO: begin
        emit       = 1'b1;
        emit_kind  = KIND_REPLY;
        phase_next = PH_DATA;
        emit_cmd   = CMD_WILL;
        case (in_byte)
          OPT_ECHO: echo_flag_next   = 1'b1;
          OPT_SGA:  sga_flag_next    = 1'b1;
          OPT_BIN:  binary_flag_next = 1'b1;
          default:  emit_cmd         = CMD_WONT;
        endcase
      end
      PH_WONT, PH_DONT: begin
        emit       = 1'b1;
        emit_kind  = KIND_REPLY;
        phase_next = PH_DATA;
        emit_cmd   = (phase == PH_WONT) ? CMD_DONT : CMD_WONT;
        if (in_byte == OPT_ECHO) echo_flag_next   = 1'b0;
        if (in_byte == OPT_SGA)  sga_flag_next    = 1'b0;
        if (in_byte == OPT_BIN)  binary_flag_next = 1'b0;
      end
      PH_SUB: begin
        if (in_byte == CMD_IAC) phase_next = PH_SUBIAC;
      end
      PH_SUBIAC: begin
        phase_next = (in_byte == CMD_SE) ? PH_DATA : PH_SUB;
      end
      default: phase_next = PH_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && emit;
    end
    if (out_free && step && emit) begin
      out_kind <= emit_kind;
      out_data <= emit_data;
      out_cmd  <= emit_cmd;
      out_opt  <= (emit_kind == KIND_REPLY) ? in_byte : 8'd0;
      out_echo <= echo_flag_next;
      out_sga  <= sga_flag_next;
      out_bin  <= binary_flag_next;
      out_last <= in_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_kind;
  assign result.payload_byte  = out_data;
  assign result.reply_command = out_cmd;
  assign result.reply_option  = out_opt;
  assign result.echo_on       = out_echo;
  assign result.sga_on        = out_sga;
  assign result.binary_on     = out_bin;
  assign result.chunk_last    = out_last;

endmodule

### verif/tb_telnet_receive_negotiation_filter.sv
// Testbench for telnet_receive_negotiation_filter: drives a received byte stream and
// checks payload items and negotiation replies against a parser kept in the bench.
// Depends on tnf_pkg, tnf_rx_if and tnf_res_if.
`timescale 1ns / 1ps

module tb_telnet_receive_negotiation_filter;
  import tnf_pkg::*;

  localparam int ITEM_TOTAL  = 1450;
  localparam int LONG_HOLD   = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] reply_command;
    logic [7:0] reply_option;
    logic       echo_on;
    logic       sga_on;
    logic       binary_on;
    logic       chunk_last;
  } filtered_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       last;
    logic       typed;
    filtered_t  want;
  } stim_row_t;

  logic clk;
  logic rst;

  tnf_rx_if  rx_ch();
  tnf_res_if res_ch();

  telnet_receive_negotiation_filter uut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  // parser state mirrored in the bench
  phase_t parse_phase = PH_DATA;
  logic   echo_st     = 1'b0;
  logic   sga_st      = 1'b0;
  logic   binary_st   = 1'b0;

  filtered_t filtered_q[$];
  stim_row_t directed_q[$];

  int        bytes_taken = 0;
  int        sent_count  = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        idle_odds   = 2;
  logic      hold_req    = 1'b0;
  logic      cur_typed   = 1'b0;
  filtered_t cur_want    = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic decode_rx_byte(input logic [7:0] c, input logic last,
                                output logic emit, output filtered_t r);
    emit = 1'b0;
    r = '0;
    r.chunk_last = last;
    case (parse_phase)
      PH_DATA: begin
        if (c == CMD_IAC) parse_phase = PH_IAC;
        else begin
          emit = 1'b1;
          r.payload_byte = c;
        end
      end
      PH_IAC: begin
        parse_phase = PH_DATA;
        case (c)
          CMD_IAC: begin
            emit = 1'b1;
            r.payload_byte = CMD_IAC;
          end
          CMD_WILL: parse_phase = PH_WILL;
          CMD_WONT: parse_phase = PH_WONT;
          CMD_DO:   parse_phase = PH_DO;
          CMD_DONT: parse_phase = PH_DONT;
          CMD_SB:   parse_phase = PH_SUB;
          default: ; // single-byte command or unknown code: dropped
        endcase
      end
      PH_WILL, PH_WONT, PH_DO, PH_DONT: begin
        emit = 1'b1;
        r.kind = KIND_REPLY;
        r.reply_option = c;
        case (parse_phase)
          PH_WILL: begin
            // echo offered by the client is refused, flag untouched
            r.reply_command = CMD_DONT;
            if (c == OPT_SGA) begin
              sga_st = 1'b1;
              r.reply_command = CMD_DO;
            end else if (c == OPT_BIN) begin
              binary_st = 1'b1;
              r.reply_command = CMD_DO;
            end else if (c == OPT_TTYPE || c == OPT_NAWS) begin
              r.reply_command = CMD_DO;
            end
          end
          PH_DO: begin
            r.reply_command = CMD_WONT;
            if (c == OPT_ECHO) begin
              echo_st = 1'b1;
              r.reply_command = CMD_WILL;
            end else if (c == OPT_SGA) begin
              sga_st = 1'b1;
              r.reply_command = CMD_WILL;
            end else if (c == OPT_BIN) begin
              binary_st = 1'b1;
              r.reply_command = CMD_WILL;
            end
          end
          default: begin
            r.reply_command = (parse_phase == PH_WONT) ? CMD_DONT : CMD_WONT;
            if (c == OPT_ECHO) echo_st = 1'b0;
            if (c == OPT_SGA) sga_st = 1'b0;
            if (c == OPT_BIN) binary_st = 1'b0;
          end
        endcase
        parse_phase = PH_DATA;
      end
      PH_SUB: begin
        if (c == CMD_IAC) parse_phase = PH_SUBIAC;
      end
      default: begin
        parse_phase = (c == CMD_SE) ? PH_DATA : PH_SUB;
      end
    endcase
    r.echo_on = echo_st;
    r.sga_on = sga_st;
    r.binary_on = binary_st;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic compare_result(input filtered_t got);
    filtered_t want;
    if (filtered_q.size() == 0) begin
      report_mismatch("result with nothing outstanding, payload_byte", got.payload_byte, -1);
      return;
    end
    want = filtered_q.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
    if (got.reply_command !== want.reply_command)
      report_mismatch("reply_command", got.reply_command, want.reply_command);
    if (got.reply_option !== want.reply_option)
      report_mismatch("reply_option", got.reply_option, want.reply_option);
    if (got.echo_on !== want.echo_on) report_mismatch("echo_on", got.echo_on, want.echo_on);
    if (got.sga_on !== want.sga_on) report_mismatch("sga_on", got.sga_on, want.sga_on);
    if (got.binary_on !== want.binary_on)
      report_mismatch("binary_on", got.binary_on, want.binary_on);
    if (got.chunk_last !== want.chunk_last)
      report_mismatch("chunk_last", got.chunk_last, want.chunk_last);
  endtask

  // results are checked before the item taken at the same edge is decoded
  always @(posedge clk) begin : handshake_watch
    filtered_t seen;
    filtered_t calc;
    logic      emit;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        seen = {res_ch.kind, res_ch.payload_byte, res_ch.reply_command, res_ch.reply_option,
                res_ch.echo_on, res_ch.sga_on, res_ch.binary_on, res_ch.chunk_last};
        compare_result(seen);
      end
      if (rx_ch.valid && rx_ch.ready) begin
        decode_rx_byte(rx_ch.rx_byte, rx_ch.chunk_end, emit, calc);
        if (emit) filtered_q.push_back(cur_typed ? cur_want : calc);
        bytes_taken++;
      end
    end
  end

  initial begin : result_sink
    int idle_left;
    idle_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        idle_left = LONG_HOLD;
      end else if (idle_left == 0 && idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
        idle_left = $urandom_range(1, 4);
      end
      if (idle_left > 0) begin
        res_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic rand_last();
    return ($urandom_range(0, 3) == 0);
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic push_byte(input logic [7:0] b, input logic last);
    int taken_before;
    int gap;
    if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
      gap = $urandom_range(1, 4);
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.rx_byte   <= b;
    rx_ch.chunk_end <= last;
    taken_before = bytes_taken;
    do @(negedge clk); while (bytes_taken == taken_before);
    sent_count++;
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    do @(negedge clk); while (filtered_q.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] rx, input logic last, input logic typed,
                         input filtered_t want);
    stim_row_t row;
    row.rx = rx;
    row.last = last;
    row.typed = typed;
    row.want = want;
    directed_q.push_back(row);
  endtask

  initial begin : stimulus
    stim_row_t  row;
    logic [7:0] b;
    logic [7:0] opt;
    int         i;
    int         n;
    int         mark;
    logic       held;
    logic       paused;

    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    rx_ch.chunk_end = 1'b0;
    held = 1'b0;
    paused = 1'b0;

    add_row(8'h00, 1'b0, 1'b1, {KIND_DATA, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(CMD_IAC, 1'b1, 1'b1, {KIND_DATA, CMD_IAC, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(CMD_WILL, 1'b1, 1'b0, '0);
    add_row(OPT_BIN, 1'b0, 1'b1, {KIND_REPLY, 8'h00, CMD_DO, OPT_BIN, 1'b0, 1'b0, 1'b1, 1'b0});
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(CMD_DO, 1'b0, 1'b0, '0);
    add_row(OPT_ECHO, 1'b0, 1'b1,
            {KIND_REPLY, 8'h00, CMD_WILL, OPT_ECHO, 1'b1, 1'b0, 1'b1, 1'b0});
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(CMD_WILL, 1'b0, 1'b0, '0);
    add_row(OPT_NAWS, 1'b1, 1'b0, '0);
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(CMD_WONT, 1'b0, 1'b0, '0);
    add_row(OPT_SGA, 1'b0, 1'b0, '0);
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(CMD_DONT, 1'b0, 1'b0, '0);
    add_row(OPT_BIN, 1'b0, 1'b0, '0);
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(8'hF1, 1'b0, 1'b0, '0);     // no-op command, dropped
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(CMD_SB, 1'b0, 1'b0, '0);
    add_row(CMD_IAC, 1'b0, 1'b0, '0);   // doubled IAC stays inside sub-negotiation
    add_row(CMD_IAC, 1'b1, 1'b0, '0);
    add_row(CMD_IAC, 1'b0, 1'b0, '0);
    add_row(CMD_SE, 1'b0, 1'b0, '0);
    add_row(8'hFE, 1'b1, 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_q.size(); i++) begin
      row = directed_q[i];
      cur_typed = row.typed;
      cur_want = row.want;
      push_byte(row.rx, row.last);
    end
    cur_typed = 1'b0;
    wait_drained();

    mark = 0;
    while (sent_count < ITEM_TOTAL) begin
      if (sent_count >= mark) begin
        mark = sent_count + 120;
        idle_odds = (sent_count >= ITEM_TOTAL - 200) ? 0 : $urandom_range(0, 3);
        if (!held && sent_count >= ITEM_TOTAL / 3) begin
          held = 1'b1;
          // IAC SE IAC SE lands in the data phase from any phase
          push_byte(CMD_IAC, 1'b0);
          push_byte(CMD_SE, 1'b0);
          push_byte(CMD_IAC, 1'b0);
          push_byte(CMD_SE, 1'b0);
          hold_req = 1'b1;
          repeat (12) push_byte(8'($urandom_range(0, 254)), rand_last());
        end
        if (!paused && sent_count >= ITEM_TOTAL / 2) begin
          paused = 1'b1;
          wait_drained();
        end
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_byte(8'($urandom_range(0, 254)), rand_last());
        4: begin
          push_byte(CMD_IAC, rand_last());
          push_byte(CMD_IAC, rand_last());
        end
        5, 6: begin
          case ($urandom_range(0, 9))
            0: opt = OPT_BIN;
            1: opt = OPT_ECHO;
            2: opt = OPT_SGA;
            3: opt = OPT_TTYPE;
            4: opt = OPT_NAWS;
            default: opt = 8'($urandom_range(0, 255));
          endcase
          push_byte(CMD_IAC, rand_last());
          push_byte(8'(CMD_WILL + $urandom_range(0, 3)), rand_last());
          push_byte(opt, rand_last());
        end
        7: begin
          push_byte(CMD_IAC, rand_last());
          push_byte(8'($urandom_range(0, 249)), rand_last());
        end
        8: begin
          push_byte(CMD_IAC, rand_last());
          push_byte(CMD_SB, rand_last());
          n = $urandom_range(0, 5);
          repeat (n) begin
            b = 8'($urandom_range(0, 255));
            push_byte(b, rand_last());
            if (b == CMD_IAC) begin
              do b = 8'($urandom_range(0, 255)); while (b == CMD_SE);
              push_byte(b, rand_last());
            end
          end
          push_byte(CMD_IAC, rand_last());
          push_byte(CMD_SE, rand_last());
        end
        default: push_byte(8'($urandom_range(0, 255)), rand_last());
      endcase
    end

    rx_ch.valid <= 1'b0;
    do @(negedge clk); while (filtered_q.size() != 0);
    repeat (8) @(negedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### telnet_receive_negotiation_filter.f
rtl/core/tnf_pkg.sv
rtl/core/tnf_rx_if.sv
rtl/core/tnf_res_if.sv
rtl/core/telnet_receive_negotiation_filter.sv
verif/tb_telnet_receive_negotiation_filter.sv
